// ===== hw/rtl/opaque_span_extractor_defines.svh =====
// assertion macros for the opaque span extractor
// expects i_clk and i_rst_n in the scope of the including module
`ifndef OPAQUE_SPAN_EXTRACTOR_DEFINES_SVH
`define OPAQUE_SPAN_EXTRACTOR_DEFINES_SVH

// plain property, checked outside reset
`define OSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// overlapping implication, checked outside reset
`define OSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ose_pkg.sv =====
// shared types and constants of the opaque span extractor
// no dependencies
package ose_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int EVQ_DEPTH   = 4;

    localparam int PIX_W      = 32;
    localparam int DIM_W      = 13;
    localparam int OFS_W      = 12;
    localparam int COORD_W    = 13;
    localparam int TOTAL_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [PIX_W-1:0] KEY_RESET = 32'h7774_7477;

    localparam logic KIND_SPAN   = 1'b0;
    localparam logic KIND_BOUNDS = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY    = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_OFS_X  = 3'd3,
        REG_OFS_Y  = 3'd4
    } t_cfg_reg;

    // what one pixel caused, as queued between front and back
    typedef struct packed {
        logic has_span;
        logic has_bounds;
    } t_ev_flags;

    localparam int EV_FLAGS_W = $bits(t_ev_flags);

endpackage

// ===== hw/rtl/ose_pix_if.sv =====
// pixel channel: valid/ready handshake with one 32-bit pixel
// depends on ose_pkg
interface ose_pix_if;
    import ose_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== hw/rtl/ose_res_if.sv =====
// result channel: valid/ready handshake with a span or bounds result
// depends on ose_pkg
interface ose_res_if;
    import ose_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic               empty_res;
    logic [TOTAL_W-1:0] span_total;
    logic               last;

    modport source (
        output valid, output kind, output top, output bottom, output left,
        output right, output empty_res, output span_total, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input top, input bottom, input left,
        input right, input empty_res, input span_total, input last,
        output ready
    );
endinterface

// ===== hw/rtl/opaque_span_extractor.sv =====
// opaque span extractor top level: config registers, front end, event queue, back end
// depends on ose_pkg, ose_pix_if, ose_res_if, ose_front, ose_evq, ose_back
// usage: pixels enter on i_pix in raster order over visible_width x visible_height;
// a pixel equal to transparent_key is transparent. each closed run of opaque pixels
// comes out on o_res as a span result (kind 0); after the last pixel of the image a
// bounds result (kind 1, last set) follows, with empty_res set if nothing was opaque.
// config is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so only
// while the block is idle, which the block does not enforce. a pixel's event enters the
// queue at its transaction edge, then the output register, where o_res.valid rises; the
// bounds from a pixel that also ends a span follows that span in the next output slot.
// throughput: one pixel per cycle while the event queue is not full; the back end drains
// one result per cycle through its single output register. the two-result pixel at image
// end takes a second output slot, absorbed by the four-entry event queue; in a 1x1 image
// every opaque pixel gives two results, so there the queue fills and i_pix.ready drops.
// a stalled receiver holds the output register; the queue fills and i_pix.ready drops.
// reset restores the register defaults and starts a fresh image at row 0, column 0.
`include "opaque_span_extractor_defines.svh"

module opaque_span_extractor #(
    parameter int MAX_DIM = ose_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ose_pix_if.sink                         i_pix,
    ose_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [ose_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ose_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ose_pkg::*;

    localparam int CW   = $clog2(MAX_DIM);
    localparam int EV_W = EV_FLAGS_W + 3 * CW;

    logic [PIX_W-1:0] r_key;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [OFS_W-1:0] r_ofs_x;
    logic [OFS_W-1:0] r_ofs_y;

    logic [CW-1:0] wlast;
    logic [CW-1:0] hlast;

    logic          ev_push;
    t_ev_flags     ev_flags;
    logic [CW-1:0] ev_row;
    logic [CW-1:0] ev_lo;
    logic [CW-1:0] ev_hi;

    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic [EV_W-1:0] q_head;
    t_ev_flags     hd_flags;
    logic [CW-1:0] hd_row;
    logic [CW-1:0] hd_lo;
    logic [CW-1:0] hd_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= KEY_RESET;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_ofs_x  <= '0;
            r_ofs_y  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY:    r_key    <= i_cfg_data[PIX_W-1:0];
                REG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                REG_OFS_X:  r_ofs_x  <= i_cfg_data[OFS_W-1:0];
                REG_OFS_Y:  r_ofs_y  <= i_cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // last column and row index: zero acts as one, large values saturate
    always_comb begin
        if (r_width == '0) begin
            wlast = '0;
        end else if (32'(r_width) > MAX_DIM) begin
            wlast = CW'(MAX_DIM - 1);
        end else begin
            wlast = CW'(r_width - DIM_W'(1));
        end
        if (r_height == '0) begin
            hlast = '0;
        end else if (32'(r_height) > MAX_DIM) begin
            hlast = CW'(MAX_DIM - 1);
        end else begin
            hlast = CW'(r_height - DIM_W'(1));
        end
    end

    ose_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_key      (r_key),
        .i_wlast    (wlast),
        .i_hlast    (hlast),
        .i_q_full   (q_full),
        .o_ev_push  (ev_push),
        .o_ev_flags (ev_flags),
        .o_ev_row   (ev_row),
        .o_ev_lo    (ev_lo),
        .o_ev_hi    (ev_hi)
    );

    ose_evq #(
        .WIDTH (EV_W),
        .DEPTH (EVQ_DEPTH)
    ) u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_push),
        .i_data  ({ev_flags, ev_row, ev_lo, ev_hi}),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {hd_flags, hd_row, hd_lo, hd_hi} = q_head;

    ose_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (!q_empty),
        .i_ev_flags (hd_flags),
        .i_ev_row   (hd_row),
        .i_ev_lo    (hd_lo),
        .i_ev_hi    (hd_hi),
        .i_ofs_x    (r_ofs_x),
        .i_ofs_y    (r_ofs_y),
        .o_ev_pop   (q_pop),
        .o_res      (o_res)
    );

    `OSE_ASSERT_IMP(a_q_no_overflow, ev_push, !q_full, "event pushed into a full queue")
    `OSE_ASSERT_IMP(a_span_ordered, ev_push && ev_flags.has_span, ev_lo <= ev_hi,
        "span start beyond span end")
    `OSE_ASSERT_IMP(a_empty_no_spans, o_res.valid && o_res.empty_res,
        o_res.span_total == '0, "empty bounds result with nonzero span count")

endmodule

// ===== hw/rtl/ose_front.sv =====
// front end: accepts pixels, tracks column, row and open run, classifies events
// depends on ose_pkg and ose_pix_if
module ose_front #(
    parameter int MAX_DIM = ose_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ose_pix_if.sink                     i_pix,
    input  logic [ose_pkg::PIX_W-1:0]   i_key,
    input  logic [$clog2(MAX_DIM)-1:0]  i_wlast,
    input  logic [$clog2(MAX_DIM)-1:0]  i_hlast,
    input  logic                        i_q_full,
    output logic                        o_ev_push,
    output ose_pkg::t_ev_flags          o_ev_flags,
    output logic [$clog2(MAX_DIM)-1:0]  o_ev_row,
    output logic [$clog2(MAX_DIM)-1:0]  o_ev_lo,
    output logic [$clog2(MAX_DIM)-1:0]  o_ev_hi
);
    import ose_pkg::*;

    localparam int CW = $clog2(MAX_DIM);

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic          r_in_run;
    logic [CW-1:0] r_run_start;

    logic accept;
    logic opaque;
    logic row_end;
    logic img_end;
    logic close_t;
    logic close_e;

    assign i_pix.ready = !i_q_full;
    assign accept      = i_pix.valid && i_pix.ready;

    assign opaque  = (i_pix.pixel != i_key);
    assign row_end = (r_col >= i_wlast);
    assign img_end = row_end && (r_row >= i_hlast);
    // a transparent pixel closes an open run; an opaque one at row end closes it too
    assign close_t = !opaque && r_in_run;
    assign close_e = row_end && opaque;

    always_comb begin
        o_ev_flags.has_span   = close_t || close_e;
        o_ev_flags.has_bounds = img_end;
        o_ev_row              = r_row;
        o_ev_lo               = (close_e && !r_in_run) ? r_col : r_run_start;
        o_ev_hi               = close_t ? (r_col - CW'(1)) : r_col;
    end

    assign o_ev_push = accept && (o_ev_flags.has_span || o_ev_flags.has_bounds);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_in_run    <= 1'b0;
            r_run_start <= '0;
        end else if (accept) begin
            r_in_run <= opaque && !row_end;
            if (opaque && !r_in_run) begin
                r_run_start <= r_col;
            end
            if (row_end) begin
                r_col <= '0;
                r_row <= img_end ? '0 : (r_row + CW'(1));
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/ose_evq.sv =====
// small event queue between front and back, flop based
// depends on ose_pkg for the default depth
module ose_evq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ose_pkg::EVQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CNTW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : (r_wptr + AW'(1));
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : (r_rptr + AW'(1));
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/ose_back.sv =====
// back end: keeps bounding box and span count, formats results into the output register
// depends on ose_pkg and ose_res_if
module ose_back #(
    parameter int MAX_DIM = ose_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_ev_valid,
    input  ose_pkg::t_ev_flags          i_ev_flags,
    input  logic [$clog2(MAX_DIM)-1:0]  i_ev_row,
    input  logic [$clog2(MAX_DIM)-1:0]  i_ev_lo,
    input  logic [$clog2(MAX_DIM)-1:0]  i_ev_hi,
    input  logic [ose_pkg::OFS_W-1:0]   i_ofs_x,
    input  logic [ose_pkg::OFS_W-1:0]   i_ofs_y,
    output logic                        o_ev_pop,
    ose_res_if.source                   o_res
);
    import ose_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int SW = ((CW > OFS_W) ? CW : OFS_W) + 1;

    function automatic logic [COORD_W-1:0] add_ofs(
        input logic [CW-1:0]    c,
        input logic [OFS_W-1:0] o
    );
        logic [SW-1:0] s;
        s = SW'(c) + SW'(o);
        return s[COORD_W-1:0];
    endfunction

    // bookkeeping
    logic               r_span_done;
    logic               r_any;
    logic [CW-1:0]      r_box_top;
    logic [CW-1:0]      r_box_bottom;
    logic [CW-1:0]      r_box_left;
    logic [CW-1:0]      r_box_right;
    logic [TOTAL_W-1:0] r_span_count;

    // output register
    logic               r_out_valid;
    logic               r_kind;
    logic [COORD_W-1:0] r_top;
    logic [COORD_W-1:0] r_bottom;
    logic [COORD_W-1:0] r_left;
    logic [COORD_W-1:0] r_right;
    logic               r_empty;
    logic [TOTAL_W-1:0] r_total;
    logic               r_last;

    logic               out_free;
    logic               fire;
    logic               do_span;
    logic [CW-1:0]      n_box_left;
    logic [CW-1:0]      n_box_right;
    logic [TOTAL_W-1:0] n_span_count;

    assign out_free = !r_out_valid || o_res.ready;
    assign fire     = out_free && i_ev_valid;
    // span part of an event goes out first, bounds part on the next slot
    assign do_span  = i_ev_flags.has_span && !r_span_done;
    assign o_ev_pop = fire && !(do_span && i_ev_flags.has_bounds);

    assign n_box_left   = (!r_any || (i_ev_lo < r_box_left)) ? i_ev_lo : r_box_left;
    assign n_box_right  = (!r_any || (i_ev_hi > r_box_right)) ? i_ev_hi : r_box_right;
    assign n_span_count = r_span_count + TOTAL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_span_done  <= 1'b0;
            r_any        <= 1'b0;
            r_box_top    <= '0;
            r_box_bottom <= '0;
            r_box_left   <= '1;
            r_box_right  <= '0;
            r_span_count <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= i_ev_valid;
            end
            if (fire) begin
                if (do_span) begin
                    if (!r_any) begin
                        r_box_top <= i_ev_row;
                    end
                    r_any        <= 1'b1;
                    r_box_left   <= n_box_left;
                    r_box_right  <= n_box_right;
                    r_box_bottom <= i_ev_row;
                    r_span_count <= n_span_count;
                    r_span_done  <= i_ev_flags.has_bounds;
                end else begin
                    r_any        <= 1'b0;
                    r_box_top    <= '0;
                    r_box_bottom <= '0;
                    r_box_left   <= '1;
                    r_box_right  <= '0;
                    r_span_count <= '0;
                    r_span_done  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (do_span) begin
                r_kind   <= KIND_SPAN;
                r_top    <= add_ofs(i_ev_row, i_ofs_y);
                r_bottom <= add_ofs(i_ev_row, i_ofs_y);
                r_left   <= add_ofs(i_ev_lo, i_ofs_x);
                r_right  <= add_ofs(i_ev_hi, i_ofs_x);
                r_empty  <= 1'b0;
                r_total  <= n_span_count;
                r_last   <= 1'b0;
            end else begin
                r_kind   <= KIND_BOUNDS;
                r_top    <= r_any ? add_ofs(r_box_top, i_ofs_y) : '0;
                r_bottom <= r_any ? add_ofs(r_box_bottom, i_ofs_y) : '0;
                r_left   <= r_any ? add_ofs(r_box_left, i_ofs_x) : '0;
                r_right  <= r_any ? add_ofs(r_box_right, i_ofs_x) : '0;
                r_empty  <= !r_any;
                r_total  <= r_span_count;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_kind;
    assign o_res.top        = r_top;
    assign o_res.bottom     = r_bottom;
    assign o_res.left       = r_left;
    assign o_res.right      = r_right;
    assign o_res.empty_res  = r_empty;
    assign o_res.span_total = r_total;
    assign o_res.last       = r_last;

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for opaque_span_extractor: scoreboard of span and bounds results
// depends on ose_pkg, ose_pix_if, ose_res_if and the opaque_span_extractor rtl
`timescale 1ns / 1ps

module tb;
    import ose_pkg::*;

    localparam int MAX_DIM       = MAX_DIM_DEF;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int EXTREME_ITEMS = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] right;
        logic               empty_res;
        logic [TOTAL_W-1:0] span_total;
        logic               last;
    } t_span_result;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_EVERY_THIRD, RDY_MOSTLY} t_ready_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ose_pix_if pix_if();
    ose_res_if res_if();

    opaque_span_extractor u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predicted configuration
    logic [PIX_W-1:0] key_q;
    logic [DIM_W-1:0] width_q;
    logic [DIM_W-1:0] height_q;
    logic [OFS_W-1:0] ofs_x_q;
    logic [OFS_W-1:0] ofs_y_q;

    // predicted scan state
    logic [11:0]        column;
    logic [11:0]        row;
    bit                 in_run;
    logic [11:0]        run_start;
    logic [11:0]        box_top;
    logic [11:0]        box_bottom;
    logic [11:0]        box_left;
    logic [11:0]        box_right;
    bit                 any_opaque;
    logic [TOTAL_W-1:0] span_count;

    t_span_result expected_results[$];
    int           fail_count = 0;
    int           burst_left = 0;
    int           hold_cycles = 0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic [COORD_W-1:0] shifted(input logic [11:0] a,
                                                   input logic [OFS_W-1:0] ofs);
        return {1'b0, a} + {1'b0, ofs};
    endfunction

    function automatic void clear_scan();
        column     = '0;
        row        = '0;
        in_run     = 1'b0;
        run_start  = '0;
        box_top    = '0;
        box_bottom = '0;
        box_left   = '1;
        box_right  = '0;
        any_opaque = 1'b0;
        span_count = '0;
    endfunction

    function automatic void record_span(input logic [11:0] first, input logic [11:0] final_col);
        t_span_result r;
        if (!any_opaque) begin
            box_top    = row;
            box_left   = first;
            box_right  = final_col;
            any_opaque = 1'b1;
        end else begin
            if (first < box_left) box_left = first;
            if (final_col > box_right) box_right = final_col;
        end
        box_bottom = row;
        span_count = span_count + 1'b1;
        r.kind       = KIND_SPAN;
        r.top        = shifted(row, ofs_y_q);
        r.bottom     = shifted(row, ofs_y_q);
        r.left       = shifted(first, ofs_x_q);
        r.right      = shifted(final_col, ofs_x_q);
        r.empty_res  = 1'b0;
        r.span_total = span_count;
        r.last       = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_pixel(input logic [PIX_W-1:0] px);
        int           w;
        int           h;
        t_span_result r;
        w = eff_dim(width_q);
        h = eff_dim(height_q);
        if (px != key_q) begin
            if (!in_run) begin
                in_run    = 1'b1;
                run_start = column;
            end
        end else if (in_run) begin
            record_span(run_start, column - 12'd1);
            in_run = 1'b0;
        end
        if (int'(column) >= w - 1) begin
            if (in_run) begin
                record_span(run_start, column);
                in_run = 1'b0;
            end
            column = '0;
            if (int'(row) >= h - 1) begin
                r.kind       = KIND_BOUNDS;
                r.span_total = span_count;
                r.last       = 1'b1;
                if (any_opaque) begin
                    r.top       = shifted(box_top, ofs_y_q);
                    r.bottom    = shifted(box_bottom, ofs_y_q);
                    r.left      = shifted(box_left, ofs_x_q);
                    r.right     = shifted(box_right, ofs_x_q);
                    r.empty_res = 1'b0;
                end else begin
                    r.top       = '0;
                    r.bottom    = '0;
                    r.left      = '0;
                    r.right     = '0;
                    r.empty_res = 1'b1;
                end
                expected_results.push_back(r);
                clear_scan();
            end else begin
                row = row + 12'd1;
            end
        end else begin
            column = column + 12'd1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // scoreboard: compare every result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_span_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no prediction pending");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(res_if.kind));
                check_field("top", 32'(want.top), 32'(res_if.top));
                check_field("bottom", 32'(want.bottom), 32'(res_if.bottom));
                check_field("left", 32'(want.left), 32'(res_if.left));
                check_field("right", 32'(want.right), 32'(res_if.right));
                check_field("empty_res", 32'(want.empty_res), 32'(res_if.empty_res));
                check_field("span_total", 32'(want.span_total), 32'(res_if.span_total));
                check_field("last", 32'(want.last), 32'(res_if.last));
            end
        end
    end

    // result sink: changing stall pattern, plus a long hold-off on request
    t_ready_mode ready_mode = RDY_ALWAYS;
    int          pattern_left = 0;
    int          stall_left = 0;
    int          phase_cnt = 0;

    always @(negedge i_clk) begin
        if (hold_cycles != 0) begin
            stall_left  = hold_cycles;
            hold_cycles = 0;
        end
        if (pattern_left == 0) begin
            ready_mode   = t_ready_mode'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        phase_cnt++;
        if (stall_left != 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else begin
            case (ready_mode)
                RDY_ALWAYS:      res_if.ready <= 1'b1;
                RDY_COIN:        res_if.ready <= 1'($urandom_range(0, 1));
                RDY_EVERY_THIRD: res_if.ready <= (phase_cnt % 3 == 0);
                default:         res_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
        end
        burst_left--;
        repeat (gap) begin
            @(negedge i_clk);
            pix_if.valid <= 1'b0;
            pix_if.pixel <= $urandom;
        end
        @(negedge i_clk);
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        predict_pixel(px);
    endtask

    // drop valid, wait for every prediction to be matched, then let the pipe empty
    task automatic settle();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_KEY:    key_q    = data[PIX_W-1:0];
            REG_WIDTH:  width_q  = data[DIM_W-1:0];
            REG_HEIGHT: height_q = data[DIM_W-1:0];
            REG_OFS_X:  ofs_x_q  = data[OFS_W-1:0];
            REG_OFS_Y:  ofs_y_q  = data[OFS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] random_pixel(input int transparent_pct);
        if ($urandom_range(0, 99) < transparent_pct) return key_q;
        if ($urandom_range(0, 4) == 0) return key_q ^ (32'h1 << $urandom_range(0, 31));
        return $urandom;
    endfunction

    task automatic test_reset_defaults();
        send_pixel(KEY_RESET);
        send_pixel(~KEY_RESET);
        settle();
    endtask

    // runs closed by a transparent pixel, by the row end, an empty row,
    // and a span and the bounds out of the last pixel
    task automatic test_run_shapes();
        write_reg(REG_KEY, 32'h0);
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 3);
        write_reg(REG_OFS_X, 0);
        write_reg(REG_OFS_Y, 0);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0001);
        send_pixel(32'h0);
        send_pixel(32'h8000_0000);
        repeat (4) send_pixel(32'h0);
        repeat (4) send_pixel($urandom | 32'h1);
        settle();
    endtask

    task automatic test_dim_limits();
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        send_pixel(32'h1234_5678);
        settle();
        // saturated width, then shrunk below the current column mid-row
        write_reg(REG_WIDTH, CFG_DATA_W'({DIM_W{1'b1}}));
        write_reg(REG_HEIGHT, 1);
        repeat (3) send_pixel(32'hA5A5_A5A5);
        settle();
        write_reg(REG_WIDTH, 2);
        send_pixel(32'h0);
        settle();
    endtask

    task automatic test_offset_extremes();
        for (int i = int'(REG_OFS_Y) + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(i[CFG_IDX_W-1:0], '1);
        write_reg(REG_KEY, 32'hFFFF_FFFF);
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 2);
        write_reg(REG_OFS_X, 4095);
        write_reg(REG_OFS_Y, 4095);
        repeat (3) send_pixel(32'h0);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h7FFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        settle();
    endtask

    // largest width and height, each cut short by narrowing the register mid-image
    task automatic test_extreme_dims();
        write_reg(REG_KEY, $urandom);
        write_reg(REG_WIDTH, MAX_DIM);
        write_reg(REG_HEIGHT, 1);
        write_reg(REG_OFS_X, $urandom_range(0, 4095));
        write_reg(REG_OFS_Y, $urandom_range(0, 4095));
        repeat (EXTREME_ITEMS) send_pixel(random_pixel(50));
        settle();
        write_reg(REG_WIDTH, 1);
        send_pixel(random_pixel(50));
        settle();
        write_reg(REG_HEIGHT, MAX_DIM);
        repeat (EXTREME_ITEMS) send_pixel(random_pixel(50));
        settle();
        write_reg(REG_HEIGHT, 1);
        send_pixel(random_pixel(50));
        settle();
    endtask

    // receiver holds off while pixels keep coming, so the event queue fills
    task automatic test_output_stall();
        write_reg(REG_KEY, 32'h0);
        write_reg(REG_WIDTH, 6);
        write_reg(REG_HEIGHT, 4);
        write_reg(REG_OFS_X, 17);
        write_reg(REG_OFS_Y, 3);
        hold_cycles = HOLD_CYCLES;
        burst_left  = 200;
        for (int i = 0; i < 72; i++) send_pixel((i % 2 == 0) ? ($urandom | 32'h1) : 32'h0);
        settle();
    endtask

    task automatic test_random_images();
        int               sent;
        int               img;
        int               count;
        int               pct;
        int               sel;
        logic [CFG_DATA_W-1:0] data;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            if (sent == 0 || $urandom_range(0, 9) < 7) begin
                sel = $urandom_range(0, 9);
                data = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
                write_reg(REG_KEY, data);
            end
            if (sent == 0 || $urandom_range(0, 9) < 7) begin
                sel = $urandom_range(0, 19);
                data = $urandom;
                if ($urandom_range(0, 4) != 0) data[CFG_DATA_W-1:DIM_W] = '0;
                data[DIM_W-1:0] = (sel == 0) ? 13'd0 :
                                  (sel < 4) ? 13'($urandom_range(13, 40)) :
                                  13'($urandom_range(1, 12));
                write_reg(REG_WIDTH, data);
            end
            if (sent == 0 || $urandom_range(0, 9) < 7) begin
                data = $urandom;
                if ($urandom_range(0, 4) != 0) data[CFG_DATA_W-1:DIM_W] = '0;
                data[DIM_W-1:0] = ($urandom_range(0, 19) == 0) ? 13'd0 :
                                  13'($urandom_range(1, 6));
                write_reg(REG_HEIGHT, data);
            end
            for (int i = int'(REG_OFS_X); i <= int'(REG_OFS_Y); i++) begin
                if (sent == 0 || $urandom_range(0, 9) < 7) begin
                    sel = $urandom_range(0, 9);
                    data = $urandom;
                    if ($urandom_range(0, 4) != 0) data[CFG_DATA_W-1:OFS_W] = '0;
                    if (sel == 0) data[OFS_W-1:0] = '0;
                    if (sel == 1) data[OFS_W-1:0] = '1;
                    write_reg(i[CFG_IDX_W-1:0], data);
                end
            end
            img = eff_dim(width_q) * eff_dim(height_q);
            // mostly whole images, sometimes a cut-off one left open for the next setting
            if ($urandom_range(0, 6) == 0) count = $urandom_range(1, img);
            else count = img * $urandom_range(1, 3);
            pct = $urandom_range(0, 10) * 10;
            repeat (count) begin
                send_pixel(random_pixel(pct));
                sent++;
            end
        end
        settle();
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("opaque_span_extractor regression: fail");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        res_if.ready = 1'b0;
        key_q    = KEY_RESET;
        width_q  = DIM_W'(1);
        height_q = DIM_W'(1);
        ofs_x_q  = '0;
        ofs_y_q  = '0;
        clear_scan();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_run_shapes();
        test_dim_limits();
        test_offset_extremes();
        test_extreme_dims();
        test_output_stall();
        test_random_images();

        settle();
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("opaque_span_extractor regression: pass");
        end else begin
            $display("opaque_span_extractor regression: fail");
        end
        $finish;
    end

endmodule

// ===== opaque_span_extractor.f =====
+incdir+hw/rtl
hw/rtl/ose_pkg.sv
hw/rtl/ose_pix_if.sv
hw/rtl/ose_res_if.sv
hw/rtl/ose_front.sv
hw/rtl/ose_evq.sv
hw/rtl/ose_back.sv
hw/rtl/opaque_span_extractor.sv
dv/tb.sv
